/* hw/rtl/assert_macros.svh */
// assertion macros used by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define DTI_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked at every edge, reset included
`define DTI_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

/* hw/rtl/dtip_pkg.sv */
// constants for the decimal text to integer parser
package dtip_pkg;

   localparam int RESULT_BITS = 32;
   localparam int MAG_W       = RESULT_BITS;
   localparam int PROD_W      = RESULT_BITS + 4;

   localparam logic [MAG_W-1:0]  POS_LIMIT  = {1'b0, {(MAG_W-1){1'b1}}};
   localparam logic [MAG_W-1:0]  NEG_LIMIT  = {1'b1, {(MAG_W-1){1'b0}}};
   localparam logic [PROD_W-1:0] PROD_LIMIT = {{(PROD_W-MAG_W){1'b0}}, POS_LIMIT};

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_FIVE  = 8'h35;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

endpackage

/* hw/rtl/decimal_text_to_int_parser.sv */
// decimal text to signed integer parser, one character per beat
// One character enters per req beat, with req_end_of_text on the last one.
// Leading characters are skipped up to the first sign or digit, then an
// optional sign and decimal digits are accumulated; parsing stops at the
// first other character or once the magnitude passes the positive limit.
// A '.' that stops parsing lets the next character round: a digit of 5 or
// more adds one, any non-digit forces the result to 0. On the last beat a
// single rsp beat carries the value saturated to RESULT_BITS signed bits,
// and the parser is ready for the next string with no gap. Throughput is
// one character per clock while the result register is not stalled; a
// character is held in the input register and its result is registered
// in the result register. The only logic between the registers is one
// shift-add of the magnitude by ten and a compare against the limit, plus
// the saturation of the final value.
`include "assert_macros.svh"

module decimal_text_to_int_parser
   import dtip_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_text_char,
   input  logic                          req_end_of_text,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [RESULT_BITS-1:0] rsp_int_value
);

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_DIGITS,
      PH_AFTER_DOT,
      PH_DONE
   } phase_type;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_eot_ff;

   // parse state
   phase_type         phase_ff, phase_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              fz_ff, fz_in;

   // result register
   logic                   rsp_valid_ff;
   logic [RESULT_BITS-1:0] value_ff, value_in;

   logic              advance;
   logic              consume;
   logic              is_digit;
   logic [3:0]        digit;
   logic [PROD_W-1:0] mag_ext;
   logic [PROD_W-1:0] prod;
   logic [MAG_W-1:0]  neg_mag;
   logic [MAG_W-1:0]  pos_mag;

   // the result register can take a beat when empty or being drained
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign consume   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_int_value = value_ff;

   assign is_digit = in_char_ff inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit    = 4'(in_char_ff - CHAR_ZERO);

   // magnitude times ten plus the digit, wide enough to see an overflow
   assign mag_ext = {{(PROD_W-MAG_W){1'b0}}, mag_ff};
   assign prod    = (mag_ext << 3) + (mag_ext << 1) + {{(PROD_W-4){1'b0}}, digit};

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      fz_in    = fz_ff;
      case (phase_ff)
         PH_SKIP: begin
            if (in_char_ff == CHAR_PLUS) begin
               phase_in = PH_DIGITS;
            end else if (in_char_ff == CHAR_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_DIGITS;
            end else if (is_digit) begin
               mag_in   = {{(MAG_W-4){1'b0}}, digit};
               phase_in = PH_DIGITS;
            end
         end
         PH_DIGITS: begin
            if (is_digit) begin
               if (prod > PROD_LIMIT) begin
                  // past the limit: park at one above it and stop
                  mag_in   = NEG_LIMIT;
                  phase_in = PH_DONE;
               end else begin
                  mag_in = prod[MAG_W-1:0];
               end
            end else if (in_char_ff == CHAR_DOT) begin
               phase_in = PH_AFTER_DOT;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_AFTER_DOT: begin
            if (is_digit) begin
               if (in_char_ff >= CHAR_FIVE) begin
                  mag_in = mag_ff + 1'b1;
               end
            end else begin
               fz_in = 1'b1;
            end
            phase_in = PH_DONE;
         end
         default: begin
         end
      endcase
   end

   // final value from the state after this character
   assign neg_mag = (mag_in > NEG_LIMIT) ? NEG_LIMIT : mag_in;
   assign pos_mag = (mag_in > POS_LIMIT) ? POS_LIMIT : mag_in;

   always_comb begin
      if (fz_in) begin
         value_in = '0;
      end else if (neg_in) begin
         value_in = RESULT_BITS'(~neg_mag + 1'b1);
      end else begin
         value_in = RESULT_BITS'(pos_mag);
      end
   end

   always_ff @(posedge clock) begin
      // payload, no reset needed
      if (!req_stall) begin
         in_char_ff <= req_text_char;
         in_eot_ff  <= req_end_of_text;
      end
      if (consume && in_eot_ff) begin
         value_ff <= value_in;
      end

      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SKIP;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         fz_ff        <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= consume && in_eot_ff;
         end
         if (consume) begin
            if (in_eot_ff) begin
               // string done, start clean for the next one
               phase_ff <= PH_SKIP;
               neg_ff   <= 1'b0;
               mag_ff   <= '0;
               fz_ff    <= 1'b0;
            end else begin
               phase_ff <= phase_in;
               neg_ff   <= neg_in;
               mag_ff   <= mag_in;
               fz_ff    <= fz_in;
            end
         end
      end
   end

   // magnitude never goes past one above the positive limit
   `DTI_ASSERT(a_mag_bound, mag_ff <= NEG_LIMIT, "magnitude out of range")

   // while digits are still taken the magnitude is within the limit
   `DTI_ASSERT(a_mag_live, (phase_ff == PH_DIGITS || phase_ff == PH_AFTER_DOT) |-> mag_ff <= POS_LIMIT, "magnitude over limit while parsing")

   // a forced zero only happens once parsing has stopped
   `DTI_ASSERT(a_fz_done, fz_ff |-> phase_ff == PH_DONE, "forced zero outside done phase")

   // a consumed last beat gives a result and a clean state
   `DTI_ASSERT(a_last_beat, (consume && in_eot_ff) |=> (rsp_valid_ff && phase_ff == PH_SKIP && !neg_ff && !fz_ff), "last beat not closed out")

   // input is never held back while the result register is free
   `DTI_ASSERT_ALWAYS(a_no_idle_stall, !rsp_valid_ff |-> !req_stall, "stall with empty result register")

endmodule

/* bench/decimal_text_to_int_parser_test.sv */
// self-checking testbench for the decimal text to signed integer parser
module decimal_text_to_int_parser_test;
   import dtip_pkg::*;

   // generous bound on the whole run, far above the slowest legal run
   localparam int CYCLE_LIMIT = 400000;
   // extra wait after every owed result has come out
   localparam int DRAIN_CYCLES = 8;

   // phases of the bench's own parse of the current string
   typedef enum logic [1:0] {
      SCAN_LEAD,
      SCAN_DIGITS,
      SCAN_FRACTION,
      SCAN_DONE
   } scan_phase_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [7:0]                    req_text_char = 8'h00;
   logic                          req_end_of_text = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [RESULT_BITS-1:0] rsp_int_value;

   // predicted parse state, mirrors the string currently being sent
   scan_phase_type                scan_phase = SCAN_LEAD;
   bit                            scan_negative = 1'b0;
   logic [63:0]                   scan_mag = '0;
   bit                            scan_zeroed = 1'b0;

   // values still owed by the block, oldest first
   logic signed [RESULT_BITS-1:0] expected_values[$];
   logic signed [RESULT_BITS-1:0] expected_front;
   // characters of the string about to be sent
   logic [7:0]                    text_buf[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int chars_sent = 0;
   int strings_sent = 0;
   int results_checked = 0;
   int cycle_count = 0;

   decimal_text_to_int_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_char   (req_text_char),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_int_value   (rsp_int_value)
   );

   always #5 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver back-pressure, changed only at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // compare every accepted result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_values.size() == 0) begin
            $error("int_value: expected none, actual %0d", rsp_int_value);
            errors++;
         end else begin
            expected_front = expected_values.pop_front();
            results_checked++;
            if (rsp_int_value !== expected_front) begin
               $error("int_value: expected %0d, actual %0d",
                      expected_front, rsp_int_value);
               errors++;
            end
         end
      end
   end

   function automatic bit is_digit_char(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic void clear_scan();
      scan_phase    = SCAN_LEAD;
      scan_negative = 1'b0;
      scan_mag      = '0;
      scan_zeroed   = 1'b0;
   endfunction

   // advance the predicted parse by one character; on the last one
   // queue the saturated signed value and start over
   function automatic void predict_char(input logic [7:0] c, input logic eot);
      logic [63:0]            lim;
      logic [63:0]            d;
      logic [63:0]            m;
      logic [RESULT_BITS-1:0] v;
      lim = '0;
      lim[RESULT_BITS-1:0] = POS_LIMIT;
      d = {56'b0, c} - {56'b0, CHAR_ZERO};
      case (scan_phase)
         SCAN_LEAD: begin
            if (c == CHAR_PLUS) begin
               scan_phase = SCAN_DIGITS;
            end else if (c == CHAR_MINUS) begin
               scan_negative = 1'b1;
               scan_phase    = SCAN_DIGITS;
            end else if (is_digit_char(c)) begin
               scan_mag   = d;
               scan_phase = SCAN_DIGITS;
            end
         end
         SCAN_DIGITS: begin
            if (is_digit_char(c)) begin
               // stop and pin the magnitude once past the positive limit
               if (scan_mag > (lim - d) / 10) begin
                  scan_mag   = lim + 1;
                  scan_phase = SCAN_DONE;
               end else begin
                  scan_mag = scan_mag * 10 + d;
               end
            end else if (c == CHAR_DOT) begin
               scan_phase = SCAN_FRACTION;
            end else begin
               scan_phase = SCAN_DONE;
            end
         end
         SCAN_FRACTION: begin
            if (is_digit_char(c)) begin
               if (c >= CHAR_FIVE) scan_mag = scan_mag + 1;
            end else begin
               scan_zeroed = 1'b1;
            end
            scan_phase = SCAN_DONE;
         end
         default: ;
      endcase
      if (eot) begin
         if (scan_zeroed) begin
            v = '0;
         end else if (scan_negative) begin
            m = (scan_mag > lim + 1) ? lim + 1 : scan_mag;
            v = '0 - m[RESULT_BITS-1:0];
         end else begin
            m = (scan_mag > lim) ? lim : scan_mag;
            v = m[RESULT_BITS-1:0];
         end
         expected_values.push_back(v);
         clear_scan();
      end
   endfunction

   // one req beat, preceded by random idle cycles
   task automatic send_char(input logic [7:0] c, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_text_char   <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
      predict_char(c, eot);
      chars_sent++;
   endtask

   // send text_buf as one string, end_of_text on its last character
   task automatic send_text_buf();
      foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
      strings_sent++;
   endtask

   task automatic send_string(input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      send_text_buf();
   endtask

   // stop sending until every owed result has come out
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // any character that the parser skips before a number starts
   function automatic logic [7:0] filler_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (is_digit_char(c) || c == CHAR_PLUS || c == CHAR_MINUS);
      return c;
   endfunction

   // nul then 0xff: nothing to parse at all
   task automatic test_no_digits();
      text_buf.delete();
      text_buf.push_back(8'h00);
      text_buf.push_back(8'hFF);
      send_text_buf();
   endtask

   task automatic test_lone_sign();
      send_string("-");
   endtask

   task automatic test_most_negative();
      send_string("-2147483648");
   endtask

   // round up, dot at the very end, non-digit after the dot
   task automatic test_fraction();
      send_string("9.5");
      send_string("7.");
      send_string("1.x");
   endtask

   task automatic test_second_sign();
      send_string("+-3");
   endtask

   // mostly well-formed numbers with random content, some pure noise
   task automatic build_random_text();
      int    kind;
      int    n;
      string near = "214748364";
      text_buf.delete();
      kind = $urandom_range(99);
      if (kind < 15) begin
         n = $urandom_range(6, 1);
         repeat (n) text_buf.push_back(8'($urandom_range(255)));
         return;
      end
      // skipped lead-in
      n = $urandom_range(2);
      repeat (n) text_buf.push_back(filler_char());
      case ($urandom_range(2))
         1: text_buf.push_back(CHAR_PLUS);
         2: text_buf.push_back(CHAR_MINUS);
         default: ;
      endcase
      case ($urandom_range(2))
         0: begin
            n = $urandom_range(4, 1);
            repeat (n) text_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
         end
         1: begin
            n = $urandom_range(12, 8);
            repeat (n) text_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
         end
         default: begin
            // right at the 32-bit boundary
            for (int i = 0; i < near.len(); i++) text_buf.push_back(near[i]);
            text_buf.push_back(CHAR_ZERO + 8'($urandom_range(9, 6)));
            if ($urandom_range(3) == 0)
               text_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
         end
      endcase
      case ($urandom_range(5))
         0, 1: begin
            text_buf.push_back(CHAR_DOT);
            text_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
         end
         2: begin
            text_buf.push_back(CHAR_DOT);
            text_buf.push_back(8'($urandom_range(255)));
         end
         3: text_buf.push_back(CHAR_DOT);
         4: begin
            n = $urandom_range(3, 1);
            repeat (n) text_buf.push_back(8'($urandom_range(255)));
         end
         default: ;
      endcase
   endtask

   task automatic test_random_strings(input int char_budget);
      int start;
      start = chars_sent;
      while (chars_sent - start < char_budget) begin
         build_random_text();
         send_text_buf();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender light idling, receiver heavy back-pressure
      send_idle_pct = 12;
      recv_idle_pct = 59;
      test_no_digits();
      test_lone_sign();
      test_most_negative();
      test_fraction();
      test_second_sign();
      test_random_strings(300);
      wait_for_results();

      // sender heavy idling, receiver light back-pressure
      send_idle_pct = 59;
      recv_idle_pct = 12;
      test_random_strings(310);
      wait_for_results();

      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_strings(310);
      wait_for_results();

      if (expected_values.size() != 0) begin
         $error("int_value: %0d expected results never arrived",
                expected_values.size());
         errors++;
      end
      $display("sent %0d strings in %0d characters, checked %0d parsed values",
               strings_sent, chars_sent, results_checked);
      $display("covered noise, signs, rounding, saturation, under three stall mixes");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* decimal_text_to_int_parser.f */
+incdir+hw/rtl
hw/rtl/dtip_pkg.sv
hw/rtl/decimal_text_to_int_parser.sv
bench/decimal_text_to_int_parser_test.sv
